### hw/rtl/tlmc_pkg.sv
// Shared types and constants for the traffic light mode controller.
package tlmc_pkg;

   localparam int CFG_WIDTH     = 16;
   localparam int CSR_IDX_WIDTH = 3;
   localparam int RSP_DEPTH     = 8;
   localparam int RSP_PTR_W     = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W     = RSP_PTR_W + 1;

   // Register indexes of the control port.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RED_TIME     = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_AMBER_TIME   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_GREEN_TIME   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BLINK_HALF   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STEADY_RPT   = 3'd4;

   localparam logic [CFG_WIDTH-1:0] RED_TIME_RST     = 16'd5000;
   localparam logic [CFG_WIDTH-1:0] AMBER_TIME_RST   = 16'd3000;
   localparam logic [CFG_WIDTH-1:0] GREEN_TIME_RST   = 16'd10000;
   localparam logic [CFG_WIDTH-1:0] BLINK_HALF_RST   = 16'd1000;
   localparam logic [CFG_WIDTH-1:0] STEADY_RPT_RST   = 16'd10000;

   // Input commands.
   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_HOST   = 2'd1;
   localparam logic [1:0] CMD_BUTTON = 2'd2;

   localparam logic [1:0] BUTTON_NONE = 2'd3;

   // Lamp bits: 0 red, 1 amber, 2 green.
   localparam logic [2:0] LAMP_OFF   = 3'b000;
   localparam logic [2:0] LAMP_RED   = 3'b001;
   localparam logic [2:0] LAMP_AMBER = 3'b010;
   localparam logic [2:0] LAMP_GREEN = 3'b100;

   // ASCII codes.
   localparam logic [7:0] CH_T   = 8'h54;
   localparam logic [7:0] CH_1   = 8'h31;
   localparam logic [7:0] CH_3   = 8'h33;
   localparam logic [7:0] CH_R   = 8'h52;
   localparam logic [7:0] CH_Y   = 8'h59;
   localparam logic [7:0] CH_G   = 8'h47;
   localparam logic [7:0] CH_O   = 8'h4F;
   localparam logic [7:0] CH_U   = 8'h55;
   localparam logic [7:0] CH_K   = 8'h4B;
   localparam logic [7:0] CH_I   = 8'h49;
   localparam logic [7:0] CH_M   = 8'h4D;
   localparam logic [7:0] CH_A   = 8'h41;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_STEADY = 2'd1,
      MODE_BLINK  = 2'd2,
      MODE_CYCLE  = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] host_byte;
      logic [1:0] button_index;
   } req_type;

   typedef struct packed {
      logic [7:0] message;
      logic [2:0] lamps;
      logic       last;
   } rsp_type;

   // Results of one transaction, pushed together into the response queue.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic [7:0] change_code(mode_type m);
      logic [7:0] code;
      case (m)
         MODE_STEADY: code = CH_U;
         MODE_BLINK:  code = CH_K;
         MODE_CYCLE:  code = CH_I;
         default:     code = CH_I;
      endcase
      return code;
   endfunction

endpackage

### hw/rtl/tlmc_core.sv
// Mode state, phase timer, control registers and per-transaction result logic.
module tlmc_core import tlmc_pkg::*; #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_data,
   input  logic                     item_valid,
   input  req_type                  item,
   output push_type                 push
);

   logic [CFG_WIDTH-1:0] red_time_ff, amber_time_ff, green_time_ff;
   logic [CFG_WIDTH-1:0] blink_half_ff, steady_rpt_ff;

   mode_type              mode_ff, mode_in;
   logic                  host_ff, host_in;
   logic [2:0]            lamp_ff, lamp_in;
   logic [TIME_WIDTH-1:0] elapsed_ff, elapsed_in;

   logic [CFG_WIDTH-1:0]  len_sel;
   logic [TIME_WIDTH-1:0] phase_len;
   logic [TIME_WIDTH:0]   tick_sum;
   logic                  chg;
   mode_type              chg_mode;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_time_ff   <= RED_TIME_RST;
         amber_time_ff <= AMBER_TIME_RST;
         green_time_ff <= GREEN_TIME_RST;
         blink_half_ff <= BLINK_HALF_RST;
         steady_rpt_ff <= STEADY_RPT_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_RED_TIME:   red_time_ff   <= csr_data;
            CSR_AMBER_TIME: amber_time_ff <= csr_data;
            CSR_GREEN_TIME: green_time_ff <= csr_data;
            CSR_BLINK_HALF: blink_half_ff <= csr_data;
            CSR_STEADY_RPT: steady_rpt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_CYCLE;
         host_ff    <= 1'b0;
         lamp_ff    <= LAMP_RED;
         elapsed_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         host_ff    <= host_in;
         lamp_ff    <= lamp_in;
         elapsed_ff <= elapsed_in;
      end
   end

   // Length of the current phase; cycle mode picks by the lit lamp, red first.
   always_comb begin
      case (mode_ff)
         MODE_STEADY: len_sel = steady_rpt_ff;
         MODE_BLINK:  len_sel = blink_half_ff;
         default: begin
            if (lamp_ff[0])      len_sel = red_time_ff;
            else if (lamp_ff[1]) len_sel = amber_time_ff;
            else if (lamp_ff[2]) len_sel = green_time_ff;
            else                 len_sel = red_time_ff;
         end
      endcase
   end

   assign phase_len = TIME_WIDTH'(len_sel);
   assign tick_sum  = {1'b0, elapsed_ff} + (TIME_WIDTH+1)'(1);

   always_comb begin
      mode_in    = mode_ff;
      host_in    = host_ff;
      lamp_in    = lamp_ff;
      elapsed_in = elapsed_ff;
      chg        = 1'b0;
      chg_mode   = MODE_CYCLE;
      push       = '0;

      if (item_valid) begin
         case (item.command)
            CMD_TICK: begin
               if (mode_ff != MODE_NONE) begin
                  if (tick_sum < {1'b0, phase_len}) begin
                     elapsed_in = tick_sum[TIME_WIDTH-1:0];
                  end else begin
                     elapsed_in = '0;
                     case (mode_ff)
                        MODE_STEADY: begin
                           lamp_in = LAMP_RED;
                           push.first.message = CH_R;
                        end
                        MODE_BLINK: begin
                           if (lamp_ff[1]) begin
                              lamp_in = LAMP_OFF;
                              push.first.message = CH_O;
                           end else begin
                              lamp_in = LAMP_AMBER;
                              push.first.message = CH_Y;
                           end
                        end
                        default: begin
                           if (lamp_ff[0]) begin
                              lamp_in = LAMP_AMBER;
                              push.first.message = CH_Y;
                           end else if (lamp_ff[1]) begin
                              lamp_in = LAMP_GREEN;
                              push.first.message = CH_G;
                           end else begin
                              lamp_in = LAMP_RED;
                              push.first.message = CH_R;
                           end
                        end
                     endcase
                     push.count       = 2'd1;
                     push.first.lamps = lamp_in;
                     push.first.last  = 1'b1;
                  end
               end
            end
            CMD_HOST: begin
               if (item.host_byte == CH_T) begin
                  host_in            = ~host_ff;
                  push.count         = 2'd1;
                  push.first.message = host_in ? CH_A : CH_M;
                  push.first.lamps   = lamp_ff;
                  push.first.last    = 1'b1;
               end else if (host_ff && item.host_byte >= CH_1 && item.host_byte <= CH_3) begin
                  chg      = 1'b1;
                  chg_mode = mode_type'(item.host_byte[1:0]);
               end
            end
            CMD_BUTTON: begin
               if (!host_ff && item.button_index != BUTTON_NONE) begin
                  chg      = 1'b1;
                  chg_mode = mode_type'(item.button_index + 2'd1);
               end
            end
            default: ;
         endcase

         // Mode change: lamps off with the change code, then the first report.
         if (chg) begin
            mode_in             = chg_mode;
            elapsed_in          = '0;
            lamp_in             = (chg_mode == MODE_BLINK) ? LAMP_AMBER : LAMP_RED;
            push.count          = 2'd2;
            push.first.message  = change_code(chg_mode);
            push.first.lamps    = LAMP_OFF;
            push.first.last     = 1'b0;
            push.second.message = (chg_mode == MODE_BLINK) ? CH_Y : CH_R;
            push.second.lamps   = lamp_in;
            push.second.last    = 1'b1;
         end
      end
   end

endmodule

### hw/rtl/tlmc_rsp_fifo.sv
// Response queue: takes up to two results per cycle, delivers one per cycle while popped.
module tlmc_rsp_fifo import tlmc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  push_type             push,
   input  logic                 pop,
   output logic                 head_valid,
   output rsp_type              head,
   output logic [RSP_CNT_W-1:0] level
);

   rsp_type                entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [RSP_PTR_W-1:0]   wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.second;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
      count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign level      = count_ff;

endmodule

### hw/rtl/traffic_light_mode_controller_top.sv
// Traffic light mode controller: input register, mode logic and response queue.
//
// Request channel (req_*): one transaction is a millisecond tick, a host byte
// or a button press. Response channel (rsp_*): ASCII report bytes with the
// lamp drive after each report; rsp_last marks the final response of a
// request. A tick or a 'T' gives at most one response, a mode change two.
// Control port (csr_*): writes the five timing registers; write only while
// no request is in flight.
//
// Path: an accepted request is captured in the input register, evaluated by
// the mode logic, and its results go into the response queue behind rsp_valid.
// Throughput: one request per cycle while the response queue (8 entries) has
// room for the two requests that may be in flight; responses leave one per
// cycle while rsp_stall is low, so a run of mode changes, two responses
// each, is paced by the response port.
// Reset: synchronous; restores the register defaults and enters cycle mode
// at the start of the red phase under manual control, queue empty.
// When the receiver asserts rsp_stall the head response holds; once the
// queue lacks room for two more results per pending request, req_stall
// rises and requests wait.
module traffic_light_mode_controller_top import tlmc_pkg::*; #(
   parameter int TIME_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic [7:0]               req_host_byte,
   input  logic [1:0]               req_button_index,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_message,
   output logic                     rsp_red_lamp,
   output logic                     rsp_amber_lamp,
   output logic                     rsp_green_lamp,
   output logic                     rsp_last,
   input  logic                     csr_wr_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]     csr_data
);

   logic                 in_valid_ff, in_valid_in;
   req_type              in_item_ff;
   logic                 req_accept;
   push_type             push;
   rsp_type              head;
   logic                 head_valid;
   logic                 rsp_pop;
   logic [RSP_CNT_W-1:0] level;
   logic [RSP_CNT_W:0]   committed;

   // Room for two results from the registered request and two from a new one.
   assign committed   = {1'b0, level} + (in_valid_ff ? (RSP_CNT_W+1)'(2) : '0);
   assign req_stall   = committed > (RSP_CNT_W+1)'(RSP_DEPTH - 2);
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= '{command: req_command, host_byte: req_host_byte,
                         button_index: req_button_index};
      end
   end

   tlmc_core #(
      .TIME_WIDTH(TIME_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .push       (push)
   );

   assign rsp_pop = head_valid && !rsp_stall;

   tlmc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_pop),
      .head_valid (head_valid),
      .head       (head),
      .level      (level)
   );

   assign rsp_valid      = head_valid;
   assign rsp_message    = head.message;
   assign rsp_red_lamp   = head.lamps[0];
   assign rsp_amber_lamp = head.lamps[1];
   assign rsp_green_lamp = head.lamps[2];
   assign rsp_last       = head.last;

endmodule

### sim/traffic_light_mode_controller_top_tb.sv
// Self-checking testbench for the traffic light mode controller.
`timescale 1ns / 100ps

module traffic_light_mode_controller_top_tb import tlmc_pkg::*; ();

   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int ITEMS_PER_SEG = 115;
   localparam int NUM_SEGMENTS  = 6;

   // Tracks lamp state and timing, and holds the reports still owed by the block.
   class report_scoreboard;
      logic [CFG_WIDTH-1:0] durations [5];
      mode_type             mode;
      bit                   host_ctl;
      logic [2:0]           lamps;
      logic [CFG_WIDTH-1:0] elapsed;
      rsp_type              pending_reports [$];
      int                   mismatches;
      int                   checked;
      int                   mode_changes;

      function void reset_state();
         durations[CSR_RED_TIME]   = RED_TIME_RST;
         durations[CSR_AMBER_TIME] = AMBER_TIME_RST;
         durations[CSR_GREEN_TIME] = GREEN_TIME_RST;
         durations[CSR_BLINK_HALF] = BLINK_HALF_RST;
         durations[CSR_STEADY_RPT] = STEADY_RPT_RST;
         mode     = MODE_CYCLE;
         host_ctl = 1'b0;
         lamps    = LAMP_RED;
         elapsed  = '0;
      endfunction

      function void write_timing(logic [CSR_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] val);
         if (idx <= CSR_STEADY_RPT)
            durations[idx] = val;
      endfunction

      function void add_report(logic [7:0] msg, bit fin);
         rsp_type r;
         r.message = msg;
         r.lamps   = lamps;
         r.last    = fin;
         pending_reports.push_back(r);
      endfunction

      function logic [CFG_WIDTH-1:0] phase_len();
         logic [CFG_WIDTH-1:0] len;
         if (mode == MODE_STEADY)
            len = durations[CSR_STEADY_RPT];
         else if (mode == MODE_BLINK)
            len = durations[CSR_BLINK_HALF];
         else if ((lamps & LAMP_RED) != LAMP_OFF)
            len = durations[CSR_RED_TIME];
         else if ((lamps & LAMP_AMBER) != LAMP_OFF)
            len = durations[CSR_AMBER_TIME];
         else if ((lamps & LAMP_GREEN) != LAMP_OFF)
            len = durations[CSR_GREEN_TIME];
         else
            len = durations[CSR_RED_TIME];
         return len;
      endfunction

      // Lamps go dark with the change code, then the new mode opens with its first report.
      function int change_mode(mode_type m);
         logic [7:0] code;
         case (m)
            MODE_STEADY: code = CH_U;
            MODE_BLINK:  code = CH_K;
            default:     code = CH_I;
         endcase
         lamps = LAMP_OFF;
         add_report(code, 1'b0);
         mode    = m;
         elapsed = '0;
         if (m == MODE_BLINK) begin
            lamps = LAMP_AMBER;
            add_report(CH_Y, 1'b1);
         end else begin
            lamps = LAMP_RED;
            add_report(CH_R, 1'b1);
         end
         mode_changes++;
         return 2;
      endfunction

      function int advance_tick();
         logic [CFG_WIDTH:0] nxt;
         logic [7:0]         msg;
         if (mode == MODE_NONE)
            return 0;
         nxt = {1'b0, elapsed} + 1'b1;
         if (nxt < {1'b0, phase_len()}) begin
            elapsed = nxt[CFG_WIDTH-1:0];
            return 0;
         end
         elapsed = '0;
         if (mode == MODE_STEADY) begin
            lamps = LAMP_RED;
            msg   = CH_R;
         end else if (mode == MODE_BLINK) begin
            if ((lamps & LAMP_AMBER) != LAMP_OFF) begin
               lamps = LAMP_OFF;
               msg   = CH_O;
            end else begin
               lamps = LAMP_AMBER;
               msg   = CH_Y;
            end
         end else if ((lamps & LAMP_RED) != LAMP_OFF) begin
            lamps = LAMP_AMBER;
            msg   = CH_Y;
         end else if ((lamps & LAMP_AMBER) != LAMP_OFF) begin
            lamps = LAMP_GREEN;
            msg   = CH_G;
         end else begin
            lamps = LAMP_RED;
            msg   = CH_R;
         end
         add_report(msg, 1'b1);
         return 1;
      endfunction

      // Returns the number of reports this transaction owes.
      function int note_request(logic [1:0] cmd, logic [7:0] hb, logic [1:0] btn);
         if (cmd == CMD_TICK)
            return advance_tick();
         if (cmd == CMD_HOST) begin
            if (hb == CH_T) begin
               host_ctl = ~host_ctl;
               add_report(host_ctl ? CH_A : CH_M, 1'b1);
               return 1;
            end
            // '1'..'3' carry the mode number in their low two bits
            if (host_ctl && hb >= CH_1 && hb <= CH_3)
               return change_mode(mode_type'(hb[1:0]));
            return 0;
         end
         if (cmd == CMD_BUTTON && !host_ctl && btn != BUTTON_NONE)
            return change_mode(mode_type'(btn + 2'd1));
         return 0;
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected report: message 8'h%h lamps %b last %b",
                        got.message, got.lamps, got.last);
            return;
         end
         want = pending_reports.pop_front();
         checked++;
         if (got.message !== want.message || got.lamps !== want.lamps ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("report %0d: expected message 8'h%h lamps %b last %b, got 8'h%h %b %b",
                        checked, want.message, want.lamps, want.last,
                        got.message, got.lamps, got.last);
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_command = CMD_TICK;
   logic [7:0]               req_host_byte = 8'h00;
   logic [1:0]               req_button_index = 2'd0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_message;
   logic                     rsp_red_lamp;
   logic                     rsp_amber_lamp;
   logic                     rsp_green_lamp;
   logic                     rsp_last;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_RED_TIME;
   logic [CFG_WIDTH-1:0]     csr_data = '0;

   report_scoreboard sb = new();
   int gap_pct;
   int stall_pct;
   int requests_sent;
   int settings_used;
   int cycles;

   traffic_light_mode_controller_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_host_byte    (req_host_byte),
      .req_button_index (req_button_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_message      (rsp_message),
      .rsp_red_lamp     (rsp_red_lamp),
      .rsp_amber_lamp   (rsp_amber_lamp),
      .rsp_green_lamp   (rsp_green_lamp),
      .rsp_last         (rsp_last),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.message = rsp_message;
         got.lamps   = {rsp_green_lamp, rsp_amber_lamp, rsp_red_lamp};
         got.last    = rsp_last;
         sb.check_report(got);
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d reports outstanding",
               cycles, sb.pending_reports.size());
      $display("FAILURE");
      $finish;
   end

   task automatic send_request(input logic [1:0] cmd, input logic [7:0] hb,
                               input logic [1:0] btn, output int n);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_host_byte    <= hb;
      req_button_index <= btn;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      n = sb.note_request(cmd, hb, btn);
      requests_sent++;
   endtask

   // Hold off the sender until every owed report is back and the block is quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      sb.write_timing(idx, val);
   endtask

   task automatic load_timing(input logic [CFG_WIDTH-1:0] red, input logic [CFG_WIDTH-1:0] amber,
                              input logic [CFG_WIDTH-1:0] green,
                              input logic [CFG_WIDTH-1:0] blink,
                              input logic [CFG_WIDTH-1:0] steady);
      write_reg(CSR_RED_TIME, red);
      write_reg(CSR_AMBER_TIME, amber);
      write_reg(CSR_GREEN_TIME, green);
      write_reg(CSR_BLINK_HALF, blink);
      write_reg(CSR_STEADY_RPT, steady);
      csr_wr_en <= 1'b0;
      settings_used++;
   endtask

   task automatic apply_setting(input int k);
      case (k)
         0: load_timing(16'd3, 16'd2, 16'd4, 16'd1, 16'd5);
         1: load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
         // short after long: counts already past the new length end on the next tick
         2: load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
         3: load_timing(16'd6, 16'd0, 16'hFFFF, 16'd3, 16'd2);
         4: load_timing(16'd2, 16'd5, 16'd3, 16'hFFFF, 16'd1);
         default: load_timing(16'd4, 16'd3, 16'd2, 16'd2, 16'd3);
      endcase
   endtask

   task automatic random_request(output int counted);
      logic [1:0] cmd;
      logic [7:0] hb;
      logic [1:0] btn;
      int         pick;
      int         n;
      pick = $urandom_range(99);
      if (pick < 55)
         cmd = CMD_TICK;
      else if (pick < 75)
         cmd = CMD_HOST;
      else if (pick < 95)
         cmd = CMD_BUTTON;
      else
         cmd = CMD_NONE;
      pick = $urandom_range(9);
      if (pick < 3)
         hb = CH_T;
      else if (pick < 7)
         hb = CH_1 + 8'($urandom_range(2));
      else
         hb = 8'($urandom_range(255));
      btn = ($urandom_range(9) == 0) ? BUTTON_NONE : 2'($urandom_range(2));
      send_request(cmd, hb, btn, n);
      counted = (cmd == CMD_TICK || n > 0) ? 1 : 0;
   endtask

   initial begin
      int n;
      int sent;
      sb.reset_state();
      gap_pct   = 0;
      stall_pct = 30;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: short phases, zero steady period
      load_timing(16'd2, 16'd1, 16'd3, 16'd2, 16'd0);
      repeat (6) send_request(CMD_TICK, 8'h00, 2'd0, n);    // red, yellow, green, red
      send_request(CMD_HOST, 8'h00, 2'd0, n);               // manual: only 'T' acts
      send_request(CMD_BUTTON, 8'hFF, BUTTON_NONE, n);
      send_request(CMD_NONE, 8'hFF, BUTTON_NONE, n);
      send_request(CMD_BUTTON, 8'h00, 2'd1, n);             // into blink
      repeat (4) send_request(CMD_TICK, 8'hFF, 2'd3, n);    // off, then on again
      send_request(CMD_BUTTON, 8'h00, 2'd0, n);             // leave blink with yellow on
      send_request(CMD_TICK, 8'h00, 2'd0, n);               // zero period acts as one
      send_request(CMD_BUTTON, 8'h00, 2'd0, n);             // same mode restarts
      send_request(CMD_HOST, CH_T, 2'd0, n);
      send_request(CMD_BUTTON, 8'h00, 2'd2, n);             // ignored under host control
      send_request(CMD_HOST, CH_1 + 8'd1, 2'd0, n);
      send_request(CMD_HOST, CH_3, 2'd0, n);
      send_request(CMD_HOST, CH_1, 2'd0, n);
      send_request(CMD_HOST, 8'hFF, 2'd0, n);
      send_request(CMD_HOST, CH_T, 2'd0, n);
      send_request(CMD_BUTTON, 8'h00, 2'd2, n);

      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         drain();
         gap_pct   = (seg < 2) ? 9 : (seg < 4) ? 72 : 0;
         stall_pct = (seg < 2) ? 72 : (seg < 4) ? 9 : 0;
         apply_setting(seg);
         sent = 0;
         while (sent < ITEMS_PER_SEG) begin
            if ($urandom_range(199) == 0)
               drain();
            random_request(n);
            sent += n;
         end
      end
      drain();

      $display("covered %0d transactions over %0d timing settings, %0d mode changes",
               requests_sent, settings_used, sb.mode_changes);
      $display("checked %0d reports, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

### files.f
hw/rtl/tlmc_pkg.sv
hw/rtl/tlmc_core.sv
hw/rtl/tlmc_rsp_fifo.sv
hw/rtl/traffic_light_mode_controller_top.sv
sim/traffic_light_mode_controller_top_tb.sv
